// File: src/stme_pkg.sv
// Package for the sync tree master election block: widths, register indexes,
// configuration bundle and the record and result item types.
// Depends on nothing; every other file imports it.
package stme_pkg;

	localparam int unsigned AddrW    = 48;
	localparam int unsigned MetricW  = 32;
	localparam int unsigned CounterW = 32;
	localparam int unsigned HeightW  = 8;
	localparam int unsigned CfgIdxW  = 2;
	localparam int unsigned CfgDataW = 48;

	// Register indexes on the configuration port.
	typedef enum logic [CfgIdxW-1:0] {
		REG_SELF_ADDRESS = 2'd0,
		REG_SELF_METRIC  = 2'd1,
		REG_SELF_COUNTER = 2'd2,
		REG_MAX_HEIGHT   = 2'd3
	} cfg_reg_t;

	localparam logic [AddrW-1:0]    SelfAddressRst = '0;
	localparam logic [MetricW-1:0]  SelfMetricRst  = MetricW'(60);
	localparam logic [CounterW-1:0] SelfCounterRst = '0;
	localparam logic [HeightW-1:0]  MaxHeightRst   = HeightW'(10);

	typedef struct packed {
		logic [AddrW-1:0]    self_address;
		logic [MetricW-1:0]  own_metric;
		logic [CounterW-1:0] own_counter;
		logic [HeightW-1:0]  max_height;
	} cfg_regs_t;

	typedef struct packed {
		logic                peer_valid;
		logic [AddrW-1:0]    peer_address;
		logic [AddrW-1:0]    peer_sync_address;
		logic [AddrW-1:0]    peer_master_address;
		logic [MetricW-1:0]  peer_master_metric;
		logic [CounterW-1:0] peer_master_counter;
		logic [HeightW-1:0]  peer_height;
		logic                last_peer;
	} peer_rec_t;

	typedef struct packed {
		logic [AddrW-1:0]    master_address;
		logic [AddrW-1:0]    sync_address;
		logic [MetricW-1:0]  top_metric;
		logic [CounterW-1:0] top_counter;
		logic [HeightW-1:0]  tree_height;
		logic                changed;
	} election_result_t;

endpackage

// File: src/stme_cfg_regs.sv
// Configuration register file of the master election block.
// Depends on stme_pkg for the register indexes and reset values.
module stme_cfg_regs (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [stme_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [stme_pkg::CfgDataW-1:0] cfg_data,
	output stme_pkg::cfg_regs_t         cfg
);
	import stme_pkg::*;

	cfg_regs_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.self_address <= SelfAddressRst;
			cfg_q.own_metric   <= SelfMetricRst;
			cfg_q.own_counter  <= SelfCounterRst;
			cfg_q.max_height   <= MaxHeightRst;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_SELF_ADDRESS: cfg_q.self_address <= cfg_data[AddrW-1:0];
				REG_SELF_METRIC:  cfg_q.own_metric   <= cfg_data[MetricW-1:0];
				REG_SELF_COUNTER: cfg_q.own_counter  <= cfg_data[CounterW-1:0];
				REG_MAX_HEIGHT:   cfg_q.max_height   <= cfg_data[HeightW-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: src/stme_elect.sv
// Running-best candidate state and the combinational compare-and-replace step.
// Depends on stme_pkg for the item types and the configuration bundle.
module stme_elect (
	input  logic                       clk,
	input  logic                       arst_n,
	input  stme_pkg::cfg_regs_t        cfg,
	input  logic                       step,
	input  stme_pkg::peer_rec_t        rec,
	output stme_pkg::election_result_t res
);
	import stme_pkg::*;

	logic                round_open_q;
	logic                best_is_peer_q;
	logic [AddrW-1:0]    best_master_q;
	logic [AddrW-1:0]    best_peer_q;
	logic [MetricW-1:0]  best_metric_q;
	logic [CounterW-1:0] best_counter_q;
	logic [HeightW-1:0]  best_height_q;
	logic [AddrW-1:0]    cur_master_q;
	logic [AddrW-1:0]    cur_sync_q;

	logic                base_is_peer;
	logic [AddrW-1:0]    base_master;
	logic [AddrW-1:0]    base_peer;
	logic [MetricW-1:0]  base_metric;
	logic [CounterW-1:0] base_counter;
	logic [HeightW-1:0]  base_height;
	logic                eligible;
	logic                wins;
	logic                take;
	logic                nxt_is_peer;
	logic [AddrW-1:0]    nxt_master;
	logic [AddrW-1:0]    nxt_peer;
	logic [MetricW-1:0]  nxt_metric;
	logic [CounterW-1:0] nxt_counter;
	logic [HeightW-1:0]  nxt_height;

	// A fresh round starts from this node itself at height zero.
	always_comb begin
		if (round_open_q) begin
			base_is_peer = best_is_peer_q;
			base_master  = best_master_q;
			base_peer    = best_peer_q;
			base_metric  = best_metric_q;
			base_counter = best_counter_q;
			base_height  = best_height_q;
		end else begin
			base_is_peer = 1'b0;
			base_master  = cfg.self_address;
			base_peer    = cfg.self_address;
			base_metric  = cfg.own_metric;
			base_counter = cfg.own_counter;
			base_height  = '0;
		end
	end

	always_comb begin
		eligible = rec.peer_valid
			&& (({1'b0, rec.peer_height} + (HeightW+1)'(1)) <= {1'b0, cfg.max_height})
			&& (rec.peer_sync_address != cfg.self_address);
		if (rec.peer_master_counter != base_counter)
			wins = rec.peer_master_counter > base_counter;
		else if (rec.peer_master_metric != base_metric)
			wins = rec.peer_master_metric > base_metric;
		else if (rec.peer_height != base_height)
			wins = rec.peer_height < base_height;
		else
			wins = rec.peer_address > base_peer;
		take = eligible && wins;
	end

	always_comb begin
		nxt_is_peer = take || base_is_peer;
		nxt_master  = take ? rec.peer_master_address : base_master;
		nxt_peer    = take ? rec.peer_address        : base_peer;
		nxt_metric  = take ? rec.peer_master_metric  : base_metric;
		nxt_counter = take ? rec.peer_master_counter : base_counter;
		nxt_height  = take ? rec.peer_height         : base_height;
	end

	always_comb begin
		res.master_address = nxt_master;
		res.sync_address   = nxt_peer;
		res.top_metric     = nxt_metric;
		res.top_counter    = nxt_counter;
		res.tree_height    = nxt_is_peer ? nxt_height + HeightW'(1) : '0;
		res.changed        = (nxt_master != cur_master_q) || (nxt_peer != cur_sync_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_open_q   <= 1'b0;
			best_is_peer_q <= 1'b0;
			cur_master_q   <= SelfAddressRst;
			cur_sync_q     <= SelfAddressRst;
		end else if (step) begin
			round_open_q   <= !rec.last_peer;
			best_is_peer_q <= nxt_is_peer;
			if (rec.last_peer) begin
				cur_master_q <= nxt_master;
				cur_sync_q   <= nxt_peer;
			end
		end
	end

	// Best candidate payload is only read while a round is open.
	always_ff @(posedge clk) begin
		if (step) begin
			best_master_q  <= nxt_master;
			best_peer_q    <= nxt_peer;
			best_metric_q  <= nxt_metric;
			best_counter_q <= nxt_counter;
			best_height_q  <= nxt_height;
		end
	end

endmodule

// File: src/sync_tree_master_election.sv
// Top level of the sync tree master election block: record input register,
// election step and result output register. Depends on stme_pkg,
// stme_cfg_regs and stme_elect.
//
//   Channel   Handshake                    Payload
//   --------  ---------------------------  -------------------------------
//   record    record_valid / record_ready  record : stme_pkg::peer_rec_t
//   result    result_valid / result_ready  result : stme_pkg::election_result_t
//   config    cfg_we (no wait)             cfg_index, cfg_data
//
// One record per cycle is sustained unless a closing record waits on a full
// output register. A record sits in the input register, where the running
// best is compared and replaced, and a record that closes the round loads its
// result into the output register as it advances; the result waits there
// until result_ready takes it.
// Reset clears the valid flags, the round state and the kept master and sync
// addresses; configuration returns to its reset values. A stalled result only
// holds back a record that closes a round; other records keep flowing.
module sync_tree_master_election (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          record_valid,
	output logic                          record_ready,
	input  stme_pkg::peer_rec_t           record,
	output logic                          result_valid,
	input  logic                          result_ready,
	output stme_pkg::election_result_t    result,
	input  logic                          cfg_we,
	input  logic [stme_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [stme_pkg::CfgDataW-1:0] cfg_data
);
	import stme_pkg::*;

	cfg_regs_t        cfg;
	peer_rec_t        rec_s1;
	logic             valid_s1;
	logic             advance;
	election_result_t elect_res;
	election_result_t result_q;
	logic             result_valid_q;

	stme_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The record in the input register is folded into the running best when
	// it can move on: always for a mid-round record, and for the closing
	// record only when the output register is free or being emptied.
	assign advance = valid_s1
		&& (!rec_s1.last_peer || !result_valid_q || result_ready);
	assign record_ready = !valid_s1 || advance;

	stme_elect u_elect (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (advance),
		.rec    (rec_s1),
		.res    (elect_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (record_ready) begin
			valid_s1 <= record_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (record_ready && record_valid) begin
			rec_s1 <= record;
		end
	end

	// The output register loads the round's result when the closing record
	// advances; otherwise it empties once the result item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (advance && rec_s1.last_peer) begin
			result_valid_q <= 1'b1;
		end else if (result_ready) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && rec_s1.last_peer) begin
			result_q <= elect_res;
		end
	end

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

// File: sim/stme_checker.sv
`timescale 1ns / 100ps
// Checker for the sync tree master election block: follows the record, result
// and configuration ports, predicts each election result and compares it.
// Depends on stme_pkg for the register indexes and the item types.
module stme_checker (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            record_valid,
	input  logic                            record_ready,
	input  stme_pkg::peer_rec_t             record,
	input  logic                            result_valid,
	input  logic                            result_ready,
	input  stme_pkg::election_result_t      result,
	input  logic                            cfg_we,
	input  logic [stme_pkg::CfgIdxW-1:0]    cfg_index,
	input  logic [stme_pkg::CfgDataW-1:0]   cfg_data,
	output int unsigned                     mismatches,
	output int unsigned                     outstanding
);
	import stme_pkg::*;

	cfg_regs_t            regs;
	logic                 round_open;
	logic                 best_is_peer;
	logic [AddrW-1:0]     best_master;
	logic [AddrW-1:0]     best_peer;
	logic [MetricW-1:0]   best_metric;
	logic [CounterW-1:0]  best_counter;
	logic [HeightW-1:0]   best_height;
	logic [AddrW-1:0]     kept_master;
	logic [AddrW-1:0]     kept_sync;
	election_result_t     expected_elections[$];

	// Counter first, then metric, then the shorter path, then the larger address.
	function automatic bit beats_best(input peer_rec_t r);
		if (r.peer_master_counter != best_counter)
			return r.peer_master_counter > best_counter;
		if (r.peer_master_metric != best_metric)
			return r.peer_master_metric > best_metric;
		if (r.peer_height != best_height)
			return r.peer_height < best_height;
		return r.peer_address > best_peer;
	endfunction

	task automatic weigh_peer(input peer_rec_t r);
		election_result_t res;
		if (!round_open) begin
			best_is_peer = 1'b0;
			best_master  = regs.self_address;
			best_peer    = regs.self_address;
			best_metric  = regs.own_metric;
			best_counter = regs.own_counter;
			best_height  = '0;
			round_open   = 1'b1;
		end
		if (r.peer_valid && ({1'b0, r.peer_height} + 9'd1 <= {1'b0, regs.max_height}) &&
				r.peer_sync_address != regs.self_address && beats_best(r)) begin
			best_is_peer = 1'b1;
			best_master  = r.peer_master_address;
			best_peer    = r.peer_address;
			best_metric  = r.peer_master_metric;
			best_counter = r.peer_master_counter;
			best_height  = r.peer_height;
		end
		if (r.last_peer) begin
			res.master_address = best_master;
			res.sync_address   = best_peer;
			res.top_metric     = best_metric;
			res.top_counter    = best_counter;
			res.tree_height    = best_is_peer ? best_height + 8'd1 : '0;
			res.changed        = (best_master != kept_master) || (best_peer != kept_sync);
			expected_elections.push_back(res);
			kept_master = best_master;
			kept_sync   = best_peer;
			round_open  = 1'b0;
		end
	endtask

	function automatic int unsigned field_bad(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected 0x%0h, got 0x%0h", name, want, got);
			return 1;
		end
		return 0;
	endfunction

	always @(posedge clk or negedge arst_n) begin : watch
		election_result_t want;
		if (!arst_n) begin
			regs.self_address = SelfAddressRst;
			regs.own_metric   = SelfMetricRst;
			regs.own_counter  = SelfCounterRst;
			regs.max_height   = MaxHeightRst;
			round_open   = 1'b0;
			best_is_peer = 1'b0;
			best_master  = '0;
			best_peer    = '0;
			best_metric  = '0;
			best_counter = '0;
			best_height  = '0;
			kept_master  = SelfAddressRst;
			kept_sync    = SelfAddressRst;
			expected_elections.delete();
			mismatches  = 0;
			outstanding = 0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_SELF_ADDRESS: regs.self_address = cfg_data[AddrW-1:0];
					REG_SELF_METRIC:  regs.own_metric   = cfg_data[MetricW-1:0];
					REG_SELF_COUNTER: regs.own_counter  = cfg_data[CounterW-1:0];
					REG_MAX_HEIGHT:   regs.max_height   = cfg_data[HeightW-1:0];
					default: ;
				endcase
			end
			if (record_valid && record_ready)
				weigh_peer(record);
			if (result_valid && result_ready) begin
				if (expected_elections.size() == 0) begin
					$error("result item 0x%0h arrived with no election pending", result);
					mismatches++;
				end else begin
					want = expected_elections.pop_front();
					mismatches += field_bad("master_address", want.master_address,
							result.master_address);
					mismatches += field_bad("sync_address", want.sync_address,
							result.sync_address);
					mismatches += field_bad("top_metric", want.top_metric,
							result.top_metric);
					mismatches += field_bad("top_counter", want.top_counter,
							result.top_counter);
					mismatches += field_bad("tree_height", want.tree_height,
							result.tree_height);
					mismatches += field_bad("changed", want.changed, result.changed);
				end
			end
			outstanding = expected_elections.size();
		end
	end

endmodule

// File: sim/sync_tree_master_election_test.sv
`timescale 1ns / 100ps
// Top of the testbench for sync_tree_master_election: clock, reset, record
// stimulus, result back-pressure, register writes and the verdict.
// Depends on stme_pkg, stme_checker and the block itself.
module sync_tree_master_election_test;
	import stme_pkg::*;

	// Percentage of cycles in which each side holds back while idling is on.
	localparam int unsigned IdlePct = 38;
	// Cycles without any accepted item or register write before giving up.
	localparam int unsigned StallLimit = 2000;
	localparam int unsigned PhaseItems = 300;
	localparam int unsigned Phases = 6;

	localparam logic [AddrW-1:0] AddrPool [4] = '{
		48'h0000_0000_0001, 48'h0A0B_0C0D_0E10, 48'h7FFF_FFFF_FFFF, 48'h8000_0000_0000
	};
	localparam logic [AddrW-1:0] SelfA = 48'h0A0B_0C0D_0E0F;
	localparam logic [AddrW-1:0] SelfB = 48'hC0FF_EE00_0001;
	localparam logic [AddrW-1:0] OtherSync = 48'h1111_2222_3333;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  record_valid = 1'b0;
	logic                  record_ready;
	peer_rec_t             record = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	election_result_t      result;
	logic                  cfg_we = 1'b0;
	logic [CfgIdxW-1:0]    cfg_index = '0;
	logic [CfgDataW-1:0]   cfg_data = '0;

	int unsigned mismatches;
	int unsigned outstanding;
	int unsigned quiet_cycles = 0;
	int unsigned items_sent = 0;
	int unsigned results_seen = 0;
	bit          idling = 1'b1;
	// Copy of the register values, used only to steer the random stimulus.
	cfg_regs_t   shadow = '{SelfAddressRst, SelfMetricRst, SelfCounterRst, MaxHeightRst};

	sync_tree_master_election u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.record_valid (record_valid),
		.record_ready (record_ready),
		.record       (record),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	stme_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.record_valid (record_valid),
		.record_ready (record_ready),
		.record       (record),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.outstanding  (outstanding)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	// The result side stalls at random on the falling edge, in step with the
	// record side, so that stalls land on every phase of the pipeline.
	always @(negedge clk) begin
		result_ready = !idling || ($urandom_range(99) >= IdlePct);
	end

	// Watchdog: any accepted item or register write counts as progress.
	always @(posedge clk) begin
		if (result_valid && result_ready)
			results_seen++;
		if ((record_valid && record_ready) || (result_valid && result_ready) || cfg_we) begin
			quiet_cycles = 0;
		end else begin
			quiet_cycles++;
			if (quiet_cycles >= StallLimit) begin
				$display("Watchdog: no progress for %0d cycles", StallLimit);
				$display("== FAIL ==");
				$finish;
			end
		end
	end

	function automatic peer_rec_t peer(input logic valid, input logic [AddrW-1:0] addr,
			input logic [AddrW-1:0] sync, input logic [AddrW-1:0] master,
			input logic [MetricW-1:0] metric, input logic [CounterW-1:0] counter,
			input logic [HeightW-1:0] height, input logic last);
		return '{valid, addr, sync, master, metric, counter, height, last};
	endfunction

	function automatic logic [AddrW-1:0] pick_addr();
		case ($urandom_range(5))
			0: return shadow.self_address;
			1: return '0;
			2: return '1;
			3, 4: return AddrPool[$urandom_range(3)];
			default: return AddrW'({$urandom, $urandom});
		endcase
	endfunction

	// Values near the given one make the comparisons tie and differ by one.
	function automatic logic [31:0] pick_word(input logic [31:0] near);
		case ($urandom_range(5))
			0: return near;
			1: return near + 32'd1;
			2: return near - 32'd1;
			3: return '0;
			4: return '1;
			default: return $urandom;
		endcase
	endfunction

	// Presents one record item and returns on the falling edge after it is
	// taken. Valid stays high into the next item unless a gap is drawn.
	task automatic send_record(input peer_rec_t r);
		while (idling && $urandom_range(99) < IdlePct) begin
			record_valid = 1'b0;
			@(negedge clk);
		end
		record = r;
		record_valid = 1'b1;
		@(posedge clk);
		while (!record_ready)
			@(posedge clk);
		@(negedge clk);
		items_sent++;
	endtask

	// Holds the sender until every election result is back, then lets the
	// pipeline empty of records that close no round.
	task automatic drain();
		record_valid = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_reg(input cfg_reg_t idx, input logic [CfgDataW-1:0] data);
		drain();
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		case (idx)
			REG_SELF_ADDRESS: shadow.self_address = data[AddrW-1:0];
			REG_SELF_METRIC:  shadow.own_metric   = data[MetricW-1:0];
			REG_SELF_COUNTER: shadow.own_counter  = data[CounterW-1:0];
			default:          shadow.max_height   = data[HeightW-1:0];
		endcase
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	initial begin
		peer_rec_t   r;
		int unsigned round_len;
		int unsigned target;
		logic [7:0]  top_height;

		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// With reset registers, a lone invalid record leaves this node master
		// and nothing has changed from the reset addresses.
		send_record(peer(1'b0, '1, '1, '1, '1, '1, '1, 1'b1));

		// One round through every skip rule and every stage of the ranking.
		write_reg(REG_SELF_ADDRESS, SelfA);
		send_record(peer(1'b1, 48'h5000_0000_0001, OtherSync, 48'hAA, 32'd60, 32'd0, 8'd3, 1'b0));
		send_record(peer(1'b1, 48'h5000_0000_0010, OtherSync, 48'hBB, 32'd60, 32'd1, 8'd9, 1'b0));
		// Height one short of the limit is fine, at the limit it is too deep.
		send_record(peer(1'b1, 48'h5000_0000_0020, OtherSync, 48'hCC, 32'd60, 32'd5, 8'd10,
				1'b0));
		// A peer that already syncs to this node is ignored.
		send_record(peer(1'b1, 48'h5000_0000_0030, SelfA, 48'hDD, 32'd60, 32'd7, 8'd1, 1'b0));
		send_record(peer(1'b0, 48'h5000_0000_0040, OtherSync, 48'hEE, 32'd60, 32'd9, 8'd1,
				1'b0));
		// Exact tie including the address: the incumbent stays.
		send_record(peer(1'b1, 48'h5000_0000_0010, OtherSync, 48'hFF, 32'd60, 32'd1, 8'd9, 1'b0));
		send_record(peer(1'b1, 48'h5000_0000_0011, OtherSync, 48'h11, 32'd60, 32'd1, 8'd9, 1'b0));
		send_record(peer(1'b1, 48'h3000_0000_0000, OtherSync, 48'h22, 32'd61, 32'd1, 8'd9, 1'b1));
		// The same winner again: nothing changed.
		send_record(peer(1'b1, 48'h3000_0000_0000, OtherSync, 48'h22, 32'd61, 32'd1, 8'd9, 1'b1));

		// Widest tree: height 254 is taken, 255 is not; all-zero and all-one
		// fields both pass through.
		write_reg(REG_MAX_HEIGHT, 48'd255);
		send_record(peer(1'b1, '1, '0, '1, '1, '1, 8'd254, 1'b0));
		send_record(peer(1'b1, '0, '0, '0, '0, '0, 8'd0, 1'b0));
		send_record('1);

		// Narrowest legal tree, then a limit of zero that shuts out every peer.
		write_reg(REG_MAX_HEIGHT, 48'd1);
		send_record(peer(1'b1, 48'h44, OtherSync, 48'h44, 32'd70, 32'd2, 8'd1, 1'b0));
		send_record(peer(1'b1, 48'h45, OtherSync, 48'h45, 32'd70, 32'd2, 8'd0, 1'b1));
		write_reg(REG_MAX_HEIGHT, 48'd0);
		send_record(peer(1'b1, 48'h46, OtherSync, 48'h46, 32'd70, 32'd3, 8'd0, 1'b1));

		// Registers written while a round is open: the running best keeps the
		// values sampled at the round's first record, but the sync check sees
		// the new own address.
		write_reg(REG_MAX_HEIGHT, 48'd10);
		send_record(peer(1'b1, 48'h47, OtherSync, 48'h47, 32'd0, 32'd0, 8'd0, 1'b0));
		write_reg(REG_SELF_COUNTER, 48'd100);
		write_reg(REG_SELF_METRIC, 48'd5);
		write_reg(REG_SELF_ADDRESS, SelfB);
		send_record(peer(1'b1, 48'h48, SelfA, 48'h48, 32'd60, 32'd50, 8'd2, 1'b0));
		send_record(peer(1'b1, 48'h49, SelfB, 48'h49, 32'd60, 32'd80, 8'd2, 1'b1));
		send_record(peer(1'b0, 48'h4A, OtherSync, 48'h4A, 32'd60, 32'd80, 8'd2, 1'b1));

		// Random phases. Each starts from a fresh register setting, with the
		// upper bits of the metric, counter and height write data filled with junk.
		// Phase three runs with no idling on either side.
		for (int ph = 0; ph < Phases; ph++) begin
			write_reg(REG_SELF_ADDRESS, ($urandom_range(1) == 0) ? AddrPool[$urandom_range(3)]
					: 48'({$urandom, $urandom}));
			write_reg(REG_SELF_METRIC, {16'($urandom), (ph == 0) ? 32'd0 : (ph == 1) ? '1
					: 32'($urandom)});
			write_reg(REG_SELF_COUNTER, {16'($urandom), (ph == 0) ? '1 : (ph == 1) ? 32'd0
					: 32'($urandom_range(3))});
			top_height = (ph == 0) ? 8'd1 : (ph == 1 || ph == 4) ? 8'd255 : (ph == 2) ? 8'd10
					: 8'($urandom_range(1, 255));
			write_reg(REG_MAX_HEIGHT, {40'({$urandom, $urandom}), top_height});
			idling = (ph != 3);
			target = items_sent + PhaseItems;
			while (items_sent < target) begin
				round_len = ($urandom_range(9) == 0) ? $urandom_range(9, 30)
						: $urandom_range(1, 8);
				for (int i = 0; i < round_len; i++) begin
					if ($urandom_range(9) == 0) begin
						// Noise: every bit random but the last_peer flag.
						r = $bits(peer_rec_t)'({$urandom, $urandom, $urandom, $urandom,
								$urandom, $urandom, $urandom});
					end else begin
						r.peer_valid          = ($urandom_range(9) != 0);
						r.peer_address        = pick_addr();
						r.peer_sync_address   = ($urandom_range(7) == 0) ? shadow.self_address
								: pick_addr();
						r.peer_master_address = pick_addr();
						r.peer_master_metric  = pick_word(shadow.own_metric);
						r.peer_master_counter = pick_word(shadow.own_counter);
						r.peer_height         = ($urandom_range(9) == 0) ? 8'($urandom)
								: 8'($urandom_range(shadow.max_height));
					end
					r.last_peer = (i == round_len - 1);
					send_record(r);
				end
			end
		end
		idling = 1'b1;

		drain();
		repeat (8) @(negedge clk);
		$display("Covered %0d peer records and %0d election results over %0d random phases,",
				items_sent, results_seen, Phases);
		$display("including tree limits of 0, 1 and 255 and register writes mid-round.");
		if (mismatches == 0 && outstanding == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
